[sv/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion core.
`default_nettype none
package rmq_pkg;

   // Field widths fixed by the interface
   localparam int FIELD_W = 18;
   localparam int DIFF_W  = 19;
   localparam int QUOT_W  = 17;

   localparam logic signed [FIELD_W-1:0] SAT_MAX = 18'sd131071;
   localparam logic signed [FIELD_W-1:0] SAT_MIN = -18'sd131072;

   // Path codes
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   // Path and validity carried alongside the arithmetic
   typedef struct packed {
      logic [1:0] branch;
      logic       inv;
   } tag_type;

   // Off-diagonal terms of one transaction, slot order w/j/k or x/y/z
   typedef struct packed {
      logic signed [DIFF_W-1:0] d0;
      logic signed [DIFF_W-1:0] d1;
      logic signed [DIFF_W-1:0] d2;
      tag_type                  tag;
   } front_type;

   // One divider lane result
   typedef struct packed {
      logic              ovf;
      logic              neg;
      logic [QUOT_W-1:0] q;
   } lane_type;

endpackage
`default_nettype wire

[sv/rmq_front.sv]
// Front stage: trace, path choice, root argument and off-diagonal terms.
`default_nettype none
module rmq_front #(
   parameter int FRAC_BITS = 16,
   parameter int ARG_W     = 21,
   parameter int RAD_W     = 38
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  en,
   input  wire                                  in_valid,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m00,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m01,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m02,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m10,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m11,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m12,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m20,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m21,
   input  wire  signed [rmq_pkg::FIELD_W-1:0]   m22,
   output logic                                 out_valid,
   output logic [RAD_W-1:0]                     out_rad,
   output rmq_pkg::front_type                   out_front
);

   localparam int SAW = ARG_W + 1;
   localparam logic signed [SAW-1:0] ONE = {{(SAW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic signed [SAW-1:0] a00, a11, a22, trace, arg;
   logic                  pick1, pick2;
   logic signed [rmq_pkg::FIELD_W-1:0] mii;
   logic                  valid_ff;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   rmq_pkg::front_type    front_ff, front_in;

   assign a00 = SAW'(m00);
   assign a11 = SAW'(m11);
   assign a22 = SAW'(m22);
   assign trace = a00 + a11 + a22;

   // Pick the largest diagonal entry, ties keep the lower index
   assign pick1 = m11 > m00;
   assign mii   = pick1 ? m11 : m00;
   assign pick2 = m22 > mii;

   always_comb begin
      front_in = '0;
      if (!trace[SAW-1] && (trace != '0)) begin
         front_in.tag.branch = rmq_pkg::BR_TRACE;
         arg         = trace + ONE;
         front_in.d0 = rmq_pkg::DIFF_W'(m12) - rmq_pkg::DIFF_W'(m21);
         front_in.d1 = rmq_pkg::DIFF_W'(m20) - rmq_pkg::DIFF_W'(m02);
         front_in.d2 = rmq_pkg::DIFF_W'(m01) - rmq_pkg::DIFF_W'(m10);
      end else if (pick2) begin
         front_in.tag.branch = rmq_pkg::BR_Z;
         arg         = a22 - a00 - a11 + ONE;
         front_in.d0 = rmq_pkg::DIFF_W'(m01) - rmq_pkg::DIFF_W'(m10);
         front_in.d1 = rmq_pkg::DIFF_W'(m02) + rmq_pkg::DIFF_W'(m20);
         front_in.d2 = rmq_pkg::DIFF_W'(m12) + rmq_pkg::DIFF_W'(m21);
      end else if (pick1) begin
         front_in.tag.branch = rmq_pkg::BR_Y;
         arg         = a11 - a22 - a00 + ONE;
         front_in.d0 = rmq_pkg::DIFF_W'(m20) - rmq_pkg::DIFF_W'(m02);
         front_in.d1 = rmq_pkg::DIFF_W'(m21) + rmq_pkg::DIFF_W'(m12);
         front_in.d2 = rmq_pkg::DIFF_W'(m01) + rmq_pkg::DIFF_W'(m10);
      end else begin
         front_in.tag.branch = rmq_pkg::BR_X;
         arg         = a00 - a11 - a22 + ONE;
         front_in.d0 = rmq_pkg::DIFF_W'(m12) - rmq_pkg::DIFF_W'(m21);
         front_in.d1 = rmq_pkg::DIFF_W'(m10) + rmq_pkg::DIFF_W'(m01);
         front_in.d2 = rmq_pkg::DIFF_W'(m20) + rmq_pkg::DIFF_W'(m02);
      end
      front_in.tag.inv = arg[SAW-1] || (arg == '0);
   end

   assign rad_in = RAD_W'(arg[ARG_W-1:0]) << FRAC_BITS;

   // Register the front results
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff   <= rad_in;
         front_ff <= front_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_front = front_ff;

endmodule
`default_nettype wire

[sv/rmq_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module rmq_sqrt #(
   parameter int ROOT_W = 19,
   parameter int SIDE_W = 60
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  wire  [2*ROOT_W-1:0] in_rad,
   input  wire  [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int RAD_W = 2 * ROOT_W;

   logic                vld_ff  [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [ROOT_W+1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [SIDE_W-1:0]   side_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              vld_src;
      logic [RAD_W-1:0]  rad_src;
      logic [ROOT_W+1:0] rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SIDE_W-1:0] side_src;
      logic [ROOT_W+1:0] rem_try, trial, rem_in;
      logic [ROOT_W-1:0] root_in;
      logic              ge;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // Bring down two radicand bits and try the next root bit
      assign rem_try = {rem_src[ROOT_W-1:0], rad_src[RAD_W-1 -: 2]};
      assign trial   = {root_src, 2'b01};
      assign ge      = rem_try >= trial;
      assign rem_in  = ge ? (rem_try - trial) : rem_try;
      assign root_in = {root_src[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_src << 2;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

[sv/rmq_div.sv]
// Pipelined three-lane rounded divide of the off-diagonal terms by twice the root.
`default_nettype none
module rmq_div #(
   parameter int FRAC_BITS = 16,
   parameter int ROOT_W    = 19
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               en,
   input  wire                               in_valid,
   input  wire  [ROOT_W-1:0]                 in_root,
   input  rmq_pkg::front_type                in_front,
   output logic                              out_valid,
   output rmq_pkg::lane_type [2:0]           out_lanes,
   output logic [rmq_pkg::FIELD_W-1:0]       out_hroot,
   output rmq_pkg::tag_type                  out_tag
);

   localparam int QB    = rmq_pkg::QUOT_W;
   localparam int NST   = QB + 1;
   localparam int DV_W  = ROOT_W + 1;
   localparam int NUM_W = rmq_pkg::DIFF_W + FRAC_BITS + 1;
   localparam int RM_W  = (NUM_W > DV_W + QB) ? NUM_W : DV_W + QB;
   localparam int HW    = ROOT_W + rmq_pkg::FIELD_W;

   logic                    vld_ff   [NST];
   logic [RM_W-1:0]         rem_ff   [NST][3];
   logic [QB-1:0]           q_ff     [NST][3];
   logic                    ovf_ff   [NST][3];
   logic                    neg_ff   [NST][3];
   logic [DV_W-1:0]         dv_ff    [NST];
   logic [rmq_pkg::FIELD_W-1:0] hroot_ff [NST];
   rmq_pkg::tag_type        tag_ff   [NST];

   // Prepare numerators, overflow flags and the saturated half root
   logic signed [rmq_pkg::DIFF_W-1:0] d_in [3];
   logic [rmq_pkg::DIFF_W-1:0]        mag  [3];
   logic [RM_W-1:0]                   num_in [3];
   logic [DV_W-1:0]                   dv_in;
   logic [HW-1:0]                     hx;
   logic [rmq_pkg::FIELD_W-1:0]       hroot_in;

   assign d_in[0] = in_front.d0;
   assign d_in[1] = in_front.d1;
   assign d_in[2] = in_front.d2;
   assign dv_in   = {in_root, 1'b0};
   assign hx      = (HW'(in_root) + HW'(1)) >> 1;
   assign hroot_in = (hx > HW'(rmq_pkg::SAT_MAX)) ?
                     rmq_pkg::SAT_MAX : rmq_pkg::FIELD_W'(hx);

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag[l]    = d_in[l][rmq_pkg::DIFF_W-1] ? rmq_pkg::DIFF_W'(-d_in[l]) :
                     rmq_pkg::DIFF_W'(d_in[l]);
         num_in[l] = (RM_W'(mag[l]) << FRAC_BITS) + RM_W'(in_root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[0][l] <= num_in[l];
            q_ff[0][l]   <= '0;
            ovf_ff[0][l] <= num_in[l] >= (RM_W'(dv_in) << QB);
            neg_ff[0][l] <= d_in[l][rmq_pkg::DIFF_W-1];
         end
         dv_ff[0]    <= dv_in;
         hroot_ff[0] <= hroot_in;
         tag_ff[0]   <= in_front.tag;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar s = 1; s < NST; s++) begin : g_stage
      localparam int B = QB - s;
      logic [RM_W-1:0] sub;

      assign sub = RM_W'(dv_ff[s-1]) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               if (rem_ff[s-1][l] >= sub) begin
                  rem_ff[s][l] <= rem_ff[s-1][l] - sub;
                  q_ff[s][l]   <= q_ff[s-1][l] | (QB'(1) << B);
               end else begin
                  rem_ff[s][l] <= rem_ff[s-1][l];
                  q_ff[s][l]   <= q_ff[s-1][l];
               end
               ovf_ff[s][l] <= ovf_ff[s-1][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
            end
            dv_ff[s]    <= dv_ff[s-1];
            hroot_ff[s] <= hroot_ff[s-1];
            tag_ff[s]   <= tag_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_lanes[l].ovf = ovf_ff[NST-1][l];
         out_lanes[l].neg = neg_ff[NST-1][l];
         out_lanes[l].q   = q_ff[NST-1][l];
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_hroot = hroot_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];

endmodule
`default_nettype wire

[sv/rotation_matrix_to_quaternion_core.sv]
// Top level: rotation matrix to unit quaternion pipeline with output register.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_m00 .. req_m22
//   rsp      out        rsp_valid/rsp_stall  rsp_qx/qy/qz/qw, branch_taken, invalid
//
// One transaction enters per cycle while req_stall is low. The pipeline holds one
// front stage, ROOT_W square-root stages (one root bit each), 18 divider stages
// and the output register. ROOT_W is 19 at FRAC_BITS = 16.
// Synchronous reset clears the valid bits only. A stalled result freezes the
// whole pipeline, so nothing is dropped or repeated.
`default_nettype none
module rotation_matrix_to_quaternion_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m00,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m01,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m02,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m10,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m11,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m12,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m20,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m21,
   input  wire  signed [rmq_pkg::FIELD_W-1:0] req_m22,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_qx,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_qy,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_qz,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_qw,
   output logic [1:0]                         rsp_branch_taken,
   output logic                               rsp_invalid
);

   localparam int ARG_W  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
   localparam int ROOT_W = (ARG_W + FRAC_BITS + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int SIDE_W = $bits(rmq_pkg::front_type);

   logic                    en;
   logic                    f_valid, s_valid, d_valid;
   logic [RAD_W-1:0]        f_rad;
   rmq_pkg::front_type      f_front, s_front;
   logic [SIDE_W-1:0]       s_side;
   logic [ROOT_W-1:0]       s_root;
   rmq_pkg::lane_type [2:0] d_lanes;
   logic [rmq_pkg::FIELD_W-1:0] d_hroot;
   rmq_pkg::tag_type        d_tag;

   logic                    rsp_valid_ff;
   logic signed [rmq_pkg::FIELD_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [rmq_pkg::FIELD_W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic signed [rmq_pkg::FIELD_W-1:0] c0, c1, c2, hr;
   logic [1:0]              branch_ff;
   logic                    invalid_ff;

   // Advance whenever the output register is free or being taken
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   rmq_front #(
      .FRAC_BITS (FRAC_BITS),
      .ARG_W     (ARG_W),
      .RAD_W     (RAD_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .m00       (req_m00),
      .m01       (req_m01),
      .m02       (req_m02),
      .m10       (req_m10),
      .m11       (req_m11),
      .m12       (req_m12),
      .m20       (req_m20),
      .m21       (req_m21),
      .m22       (req_m22),
      .out_valid (f_valid),
      .out_rad   (f_rad),
      .out_front (f_front)
   );

   rmq_sqrt #(
      .ROOT_W (ROOT_W),
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rad    (f_rad),
      .in_side   (f_front),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   assign s_front = s_side;

   rmq_div #(
      .FRAC_BITS (FRAC_BITS),
      .ROOT_W    (ROOT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_front  (s_front),
      .out_valid (d_valid),
      .out_lanes (d_lanes),
      .out_hroot (d_hroot),
      .out_tag   (d_tag)
   );

   // Saturate and sign one divider lane
   function automatic logic signed [rmq_pkg::FIELD_W-1:0] lane_value(
      input rmq_pkg::lane_type ln
   );
      logic signed [rmq_pkg::FIELD_W-1:0] mag;
      mag = {1'b0, ln.q};
      if (ln.ovf) begin
         lane_value = ln.neg ? rmq_pkg::SAT_MIN : rmq_pkg::SAT_MAX;
      end else begin
         lane_value = ln.neg ? -mag : mag;
      end
   endfunction

   assign c0 = lane_value(d_lanes[0]);
   assign c1 = lane_value(d_lanes[1]);
   assign c2 = lane_value(d_lanes[2]);
   assign hr = d_hroot;

   // Route root and lanes to the components by path
   always_comb begin
      qx_in = '0;
      qy_in = '0;
      qz_in = '0;
      qw_in = '0;
      if (!d_tag.inv) begin
         unique case (d_tag.branch)
            rmq_pkg::BR_TRACE: begin
               qx_in = c0; qy_in = c1; qz_in = c2; qw_in = hr;
            end
            rmq_pkg::BR_X: begin
               qx_in = hr; qw_in = c0; qy_in = c1; qz_in = c2;
            end
            rmq_pkg::BR_Y: begin
               qy_in = hr; qw_in = c0; qz_in = c1; qx_in = c2;
            end
            default: begin
               qz_in = hr; qw_in = c0; qx_in = c1; qy_in = c2;
            end
         endcase
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff      <= qx_in;
         qy_ff      <= qy_in;
         qz_ff      <= qz_in;
         qw_ff      <= qw_in;
         branch_ff  <= d_tag.branch;
         invalid_ff <= d_tag.inv;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_qx           = qx_ff;
   assign rsp_qy           = qy_ff;
   assign rsp_qz           = qz_ff;
   assign rsp_qw           = qw_ff;
   assign rsp_branch_taken = branch_ff;
   assign rsp_invalid      = invalid_ff;

endmodule
`default_nettype wire

[tb/tb_rotation_matrix_to_quaternion_core.sv]
// Self-checking testbench for the rotation matrix to quaternion core.
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;

   localparam int FRAC     = 16;
   localparam int ONE      = 1 << FRAC;
   localparam int LATENCY  = 19 + 20;
   localparam int WDOG_MAX = 4000;

   typedef logic signed [rmq_pkg::FIELD_W-1:0] fld_type;

   typedef struct packed {
      fld_type    qx;
      fld_type    qy;
      fld_type    qz;
      fld_type    qw;
      logic [1:0] branch;
      logic       inv;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   fld_type req_m00 = '0, req_m01 = '0, req_m02 = '0;
   fld_type req_m10 = '0, req_m11 = '0, req_m12 = '0;
   fld_type req_m20 = '0, req_m21 = '0, req_m22 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   fld_type rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic [1:0] rsp_branch_taken;
   logic rsp_invalid;

   quat_type quat_queue[$];
   int    errors = 0;
   int    sent = 0;
   int    received = 0;
   int    invalid_seen = 0;
   int    branch_seen[4] = '{0, 0, 0, 0};
   int    idle_cycles = 0;
   bit    hold_rsp = 1'b0;

   rotation_matrix_to_quaternion_core #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(req_m00), .req_m01(req_m01), .req_m02(req_m02),
      .req_m10(req_m10), .req_m11(req_m11), .req_m12(req_m12),
      .req_m20(req_m20), .req_m21(req_m21), .req_m22(req_m22),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz), .rsp_qw(rsp_qw),
      .rsp_branch_taken(rsp_branch_taken), .rsp_invalid(rsp_invalid)
   );

   always #1 clock = ~clock;

   // Integer square root, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic fld_type clamp18(longint v);
      if (v > 131071) return rmq_pkg::SAT_MAX;
      if (v < -131072) return rmq_pkg::SAT_MIN;
      return fld_type'(v);
   endfunction

   // d * 0.5 / root, half away from zero
   function automatic fld_type half_over_root(longint d, longint unsigned r);
      longint unsigned mag, q;
      mag = (d < 0) ? -d : d;
      q = ((mag << FRAC) + r) / (2 * r);
      if (q > 64'h40000) q = 64'h40000;
      return clamp18((d < 0) ? -longint'(q) : longint'(q));
   endfunction

   // Shepperd conversion of one matrix
   function automatic quat_type shepperd(fld_type m[3][3]);
      longint mm[3][3];
      longint q[4];
      longint tr, arg;
      longint unsigned r;
      int i, j, k;
      quat_type res;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++) mm[a][b] = m[a][b];
      q = '{0, 0, 0, 0};
      i = 0;
      tr = mm[0][0] + mm[1][1] + mm[2][2];
      if (tr > 0) begin
         res.branch = rmq_pkg::BR_TRACE;
         arg = tr + ONE;
      end else begin
         if (mm[1][1] > mm[0][0]) i = 1;
         if (mm[2][2] > mm[i][i]) i = 2;
         res.branch = (i == 0) ? rmq_pkg::BR_X : (i == 1) ? rmq_pkg::BR_Y : rmq_pkg::BR_Z;
      end
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      if (tr <= 0) arg = mm[i][i] - mm[j][j] - mm[k][k] + ONE;
      res.inv = (arg <= 0);
      if (arg > 0) begin
         r = int_sqrt(longint'(arg) << FRAC);
         if (res.branch == rmq_pkg::BR_TRACE) begin
            q[3] = clamp18((r + 1) >> 1);
            q[0] = half_over_root(mm[1][2] - mm[2][1], r);
            q[1] = half_over_root(mm[2][0] - mm[0][2], r);
            q[2] = half_over_root(mm[0][1] - mm[1][0], r);
         end else begin
            q[i] = clamp18((r + 1) >> 1);
            q[3] = half_over_root(mm[j][k] - mm[k][j], r);
            q[j] = half_over_root(mm[j][i] + mm[i][j], r);
            q[k] = half_over_root(mm[k][i] + mm[i][k], r);
         end
      end
      res.qx = fld_type'(q[0]);
      res.qy = fld_type'(q[1]);
      res.qz = fld_type'(q[2]);
      res.qw = fld_type'(q[3]);
      return res;
   endfunction

   // Offer one matrix, hold it until accepted, then add a random gap when gaps is set
   task automatic send_matrix(fld_type m[3][3], bit gaps = 1'b1);
      int gap;
      req_m00 <= m[0][0]; req_m01 <= m[0][1]; req_m02 <= m[0][2];
      req_m10 <= m[1][0]; req_m11 <= m[1][1]; req_m12 <= m[1][2];
      req_m20 <= m[2][0]; req_m21 <= m[2][1]; req_m22 <= m[2][2];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      quat_queue.push_back(shepperd(m));
      sent++;
      gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13)) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid at once and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (quat_queue.size() != 0) @(negedge clock);
   endtask

   function automatic fld_type rand_fld();
      case ($urandom_range(0, 5))
         0: return rmq_pkg::SAT_MIN;
         1: return rmq_pkg::SAT_MAX;
         2: return fld_type'($urandom_range(0, 2 * ONE) - ONE);
         default: return fld_type'($urandom);
      endcase
   endfunction

   // A proper rotation from a random normalised quaternion
   task automatic make_rotation(output fld_type m[3][3]);
      real a, b, c, d, n;
      a = $urandom_range(0, 2000) - 1000.0;
      b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0;
      d = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin a = 1.0; n = 1.0; end
      a /= n; b /= n; c /= n; d /= n;
      m[0][0] = fld_type'($rtoi(ONE * (1 - 2 * (c * c + d * d))));
      m[0][1] = fld_type'($rtoi(ONE * 2 * (b * c + a * d)));
      m[0][2] = fld_type'($rtoi(ONE * 2 * (b * d - a * c)));
      m[1][0] = fld_type'($rtoi(ONE * 2 * (b * c - a * d)));
      m[1][1] = fld_type'($rtoi(ONE * (1 - 2 * (b * b + d * d))));
      m[1][2] = fld_type'($rtoi(ONE * 2 * (c * d + a * b)));
      m[2][0] = fld_type'($rtoi(ONE * 2 * (b * d + a * c)));
      m[2][1] = fld_type'($rtoi(ONE * 2 * (c * d - a * b)));
      m[2][2] = fld_type'($rtoi(ONE * (1 - 2 * (b * b + c * c))));
   endtask

   // Extremes, each path and ties
   task automatic test_directed();
      fld_type m[3][3];
      m = '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};  send_matrix(m);
      m = '{'{ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE}}; send_matrix(m);
      m = '{'{-ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, -ONE}}; send_matrix(m);
      m = '{'{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, ONE}}; send_matrix(m);
      m = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};         send_matrix(m);
      m = '{'{-ONE, 5, 7}, '{9, -ONE, 3}, '{2, 4, -ONE}}; send_matrix(m);
      m = '{'{rmq_pkg::SAT_MIN, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN},
            '{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN, rmq_pkg::SAT_MAX},
            '{rmq_pkg::SAT_MIN, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN}};
      send_matrix(m);
      m = '{'{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MAX},
            '{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MAX},
            '{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MAX}};
      send_matrix(m);
      m = '{'{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN, rmq_pkg::SAT_MAX},
            '{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN, rmq_pkg::SAT_MIN},
            '{rmq_pkg::SAT_MIN, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN}};
      send_matrix(m);
      m = '{'{0, rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN},
            '{rmq_pkg::SAT_MIN, rmq_pkg::SAT_MIN, rmq_pkg::SAT_MAX},
            '{rmq_pkg::SAT_MAX, rmq_pkg::SAT_MIN, rmq_pkg::SAT_MIN}};
      send_matrix(m);
      m = '{'{-3, 0, 0}, '{0, -3, 0}, '{0, 0, -3}};       send_matrix(m);
      m = '{'{0, 1, -1}, '{-1, 0, 1}, '{1, -1, 0}};       send_matrix(m);
      m = '{'{1, 0, 0}, '{0, 0, 0}, '{0, 0, -1}};         send_matrix(m);
      m = '{'{rmq_pkg::SAT_MIN, 0, 0}, '{0, rmq_pkg::SAT_MAX, 0},
            '{0, 0, rmq_pkg::SAT_MIN}};
      send_matrix(m);
   endtask

   // Mostly proper rotations, the rest arbitrary entries
   task automatic test_random(int count);
      fld_type m[3][3];
      repeat (count) begin
         if ($urandom_range(0, 3) != 0) make_rotation(m);
         else foreach (m[a, b]) m[a][b] = rand_fld();
         send_matrix(m);
      end
   endtask

   // Hold the result side off while the sender keeps offering back to back
   task automatic test_backpressure();
      fld_type m[3][3];
      hold_rsp = 1'b1;
      repeat (80) begin
         make_rotation(m);
         send_matrix(m, 1'b0);
      end
      drain();
   endtask

   // Release the hold after a long count, independent of the sender
   always @(negedge clock) begin
      if (hold_rsp) begin
         repeat (150) @(negedge clock);
         hold_rsp = 1'b0;
      end
   end

   // Drive the receive stall: long hold, or a random wait per result
   initial begin
      int wait_n;
      wait_n = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            wait_n--;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid === 1'b1) begin
               wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            end
         end
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      quat_type exp_q, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_qx, rsp_qy, rsp_qz, rsp_qw, rsp_branch_taken, rsp_invalid};
         received++;
         if (quat_queue.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
         end else begin
            exp_q = quat_queue.pop_front();
            branch_seen[got.branch]++;
            if (got.inv) invalid_seen++;
            if (got.qx !== exp_q.qx) begin
               $display("%0t: qx exp %0d got %0d", $time, exp_q.qx, got.qx); errors++;
            end
            if (got.qy !== exp_q.qy) begin
               $display("%0t: qy exp %0d got %0d", $time, exp_q.qy, got.qy); errors++;
            end
            if (got.qz !== exp_q.qz) begin
               $display("%0t: qz exp %0d got %0d", $time, exp_q.qz, got.qz); errors++;
            end
            if (got.qw !== exp_q.qw) begin
               $display("%0t: qw exp %0d got %0d", $time, exp_q.qw, got.qw); errors++;
            end
            if (got.branch !== exp_q.branch) begin
               $display("%0t: branch exp %0d got %0d", $time, exp_q.branch, got.branch);
               errors++;
            end
            if (got.inv !== exp_q.inv) begin
               $display("%0t: invalid exp %0b got %0b", $time, exp_q.inv, got.inv);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain();
      test_random(600);
      test_backpressure();
      test_random(600);
      drain();
      repeat (LATENCY + 10) @(negedge clock);
      $display("Sent %0d matrices, checked %0d quaternions, %0d invalid.",
               sent, received, invalid_seen);
      $display("Paths: trace %0d, x %0d, y %0d, z %0d.",
               branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
      if (errors == 0 && quat_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_core.sv
tb/tb_rotation_matrix_to_quaternion_core.sv
